// ===== src/psmq_pkg.sv =====
`default_nettype none
package psmq_pkg;

    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_LEVEL_COUNT  = 4;
    localparam int DEF_ELAPSED_BITS = 16;

    localparam int ID_W     = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int RUNLVL_W = 2;
    localparam int BOOST_W  = 4;
    localparam int PICKS_W  = 9;
    localparam logic [PICKS_W-1:0] PICKS_MAX = 9'd511;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_PREEMPT = 2'd1;
    localparam logic [OP_W-1:0] OP_YIELD   = 2'd2;
    localparam logic [OP_W-1:0] OP_EXIT    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_BOOST  = 1'b1;

    localparam logic POLICY_MLFQ = 1'b0;
    localparam logic POLICY_SJF  = 1'b1;

    localparam logic               POLICY_RESET = POLICY_SJF;
    localparam logic [BOOST_W-1:0] BOOST_RESET  = 4'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_SORT,
        S_FLAT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_new;
        logic take_right;
        logic take_left;
        logic clr_level;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/psmq_cell.sv =====
`default_nettype none
module psmq_cell #(
    parameter int RW = 27,
    parameter int LW = 2
) (
    input  wire logic                 clk,
    input  wire psmq_pkg::cell_ctl_t  ctl,
    input  wire logic [RW-1:0]        new_rec,
    input  wire logic [RW-1:0]        left_rec,
    input  wire logic [RW-1:0]        right_rec,
    output logic [RW-1:0]             rec
);
    import psmq_pkg::*;

    logic [RW-1:0] rec_reg;
    logic [RW-1:0] rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        priority if (ctl.load_new)
        begin
            rec_next = new_rec;
        end
        else if (ctl.take_right)
        begin
            rec_next = right_rec;
        end
        else if (ctl.take_left)
        begin
            rec_next = left_rec;
        end
        else if (ctl.clr_level)
        begin
            rec_next = {rec_reg[RW-1:LW], {LW{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule
`default_nettype wire

// ===== src/psjf_mlfq_ready_scheduler_top.sv =====
`default_nettype none
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   op, add_id
// out       output     out_valid/out_stall dispatched, run_id, run_level, boosted, status
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An add, or an item that dispatches nothing, goes from the idle state straight to the completion state.
// A dispatch runs a serial minimum scan over the queued cells, then a removal step.
// A boost adds an odd-even transposition pass over the cell row, then a step that clears every level.
// Reset clears the count, the running thread and the pick counters; the table needs no clearing.
// A new transaction is taken while a finished result waits on a stalled output.
module psjf_mlfq_ready_scheduler_top #(
    parameter int TABLE_DEPTH  = psmq_pkg::DEF_TABLE_DEPTH,
    parameter int LEVEL_COUNT  = psmq_pkg::DEF_LEVEL_COUNT,
    parameter int ELAPSED_BITS = psmq_pkg::DEF_ELAPSED_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [psmq_pkg::OP_W-1:0]     op,
    input  wire logic [psmq_pkg::ID_W-1:0]     add_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               dispatched,
    output logic [psmq_pkg::ID_W-1:0]          run_id,
    output logic [psmq_pkg::RUNLVL_W-1:0]      run_level,
    output logic                               boosted,
    output logic [psmq_pkg::STATUS_W-1:0]      status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [psmq_pkg::BOOST_W-1:0]  cfg_data
);
    import psmq_pkg::*;

    localparam int LW    = (LEVEL_COUNT > 2) ? $clog2(LEVEL_COUNT) : 1;
    localparam int EB    = ELAPSED_BITS;
    localparam int RW    = ID_W + EB + 1 + LW;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int THR_W = BOOST_W + CW;
    localparam int CMP_W = (THR_W > PICKS_W) ? THR_W : PICKS_W;
    localparam int YB    = LW;
    localparam int EL    = LW + 1;
    localparam logic [LW-1:0] LAST_LEVEL = LW'(LEVEL_COUNT - 1);
    localparam logic [EB-1:0] ELAPSED_MAX = {EB{1'b1}};

    state_t state_reg, state_next;

    logic              policy_reg, policy_next;
    logic [BOOST_W-1:0] boost_mul_reg, boost_mul_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              rv_reg, rv_next;
    logic [RW-1:0]     run_rec_reg, run_rec_next;
    logic [LW-1:0]     last_lvl_reg, last_lvl_next;
    logic [PICKS_W-1:0] picks_reg, picks_next;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [EB-1:0]     best_key_reg, best_key_next;
    logic [RW-1:0]     best_rec_reg, best_rec_next;
    logic [IW-1:0]     phase_reg, phase_next;
    logic              res_disp_reg, res_disp_next;
    logic              res_boost_reg, res_boost_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic              dispatched_reg;
    logic [ID_W-1:0]   run_id_reg;
    logic [RUNLVL_W-1:0] run_level_reg;
    logic              boosted_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [RW-1:0]     cell_rec [TABLE_DEPTH];
    logic [RW-1:0]     new_rec;
    logic              load_tail;
    logic [TABLE_DEPTH-1:0] swap;
    logic [RW-1:0]     scan_rec;
    logic [EB-1:0]     scan_key;
    logic [RW-1:0]     mod_rec;
    logic [EB-1:0]     mod_el;
    logic              in_take;
    logic              out_load;
    logic [THR_W-1:0]  threshold;
    logic              boost_hit;
    logic [CW-1:0]     count_dec;

    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = (state_reg == S_IDLE);

    assign scan_rec = cell_rec[scan_idx_reg];
    assign scan_key = (policy_reg == POLICY_SJF) ? scan_rec[EL +: EB]
                                                : EB'(scan_rec[LW-1:0]);
    assign count_dec = count_reg - CW'(1);
    assign threshold = THR_W'(boost_mul_reg) * THR_W'(count_dec);

    always_comb
    begin
        mod_rec = run_rec_reg;
        mod_el  = run_rec_reg[EL +: EB];
        if (mod_el != ELAPSED_MAX)
        begin
            mod_el = mod_el + EB'(1);
        end
        if (op == OP_PREEMPT)
        begin
            if (policy_reg == POLICY_SJF)
            begin
                mod_rec[EL +: EB] = mod_el;
            end
            else if (run_rec_reg[LW-1:0] != LAST_LEVEL)
            begin
                mod_rec[LW-1:0] = run_rec_reg[LW-1:0] + LW'(1);
            end
        end
        else if (policy_reg == POLICY_SJF)
        begin
            mod_rec[YB] = !run_rec_reg[YB];
            if (run_rec_reg[YB])
            begin
                mod_rec[EL +: EB] = mod_el;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (op == OP_ADD)
                    begin
                        state_next = S_DONE;
                    end
                    else if (op == OP_EXIT)
                    begin
                        state_next = (rv_reg && count_reg != '0) ? S_SCAN : S_DONE;
                    end
                    else
                    begin
                        state_next = (rv_reg || count_reg != '0) ? S_SCAN : S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if ((CW'(scan_idx_reg) + CW'(1)) == count_reg)
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                state_next = boost_hit ? S_SORT : S_DONE;
            end
            S_SORT:
            begin
                if (phase_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_FLAT;
                end
            end
            S_FLAT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = (state_reg != S_IDLE);
        policy_next     = policy_reg;
        boost_mul_next  = boost_mul_reg;
        count_next      = count_reg;
        rv_next         = rv_reg;
        run_rec_next    = run_rec_reg;
        last_lvl_next   = last_lvl_reg;
        picks_next      = picks_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_key_next   = best_key_reg;
        best_rec_next   = best_rec_reg;
        phase_next      = phase_reg;
        res_disp_next   = res_disp_reg;
        res_boost_next  = res_boost_reg;
        res_status_next = res_status_reg;
        new_rec         = {add_id, {(EB + 1 + LW){1'b0}}};
        load_tail       = 1'b0;
        boost_hit       = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POLICY)
            begin
                policy_next = cfg_data[0];
            end
            else
            begin
                boost_mul_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                scan_idx_next   = '0;
                res_disp_next   = 1'b0;
                res_boost_next  = 1'b0;
                res_status_next = ST_OK;
                if (in_take)
                begin
                    if (op == OP_ADD)
                    begin
                        if (({1'b0, count_reg} + (CW + 1)'(rv_reg)) >= (CW + 1)'(TABLE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            load_tail  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (op == OP_EXIT)
                    begin
                        if (!rv_reg)
                        begin
                            res_status_next = ST_NO_RUN;
                        end
                        else
                        begin
                            rv_next      = 1'b0;
                            run_rec_next = '0;
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                        end
                    end
                    else
                    begin
                        if (rv_reg)
                        begin
                            new_rec    = mod_rec;
                            load_tail  = 1'b1;
                            count_next = count_reg + CW'(1);
                            rv_next    = 1'b0;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == '0 || scan_key < best_key_reg)
                begin
                    best_key_next = scan_key;
                    best_idx_next = scan_idx_reg;
                    best_rec_next = scan_rec;
                end
                scan_idx_next = scan_idx_reg + IW'(1);
            end
            S_REMOVE:
            begin
                count_next    = count_dec;
                rv_next       = 1'b1;
                run_rec_next  = best_rec_reg;
                res_disp_next = 1'b1;
                phase_next    = '0;
                if (policy_reg == POLICY_MLFQ)
                begin
                    if (best_rec_reg[LW-1:0] == last_lvl_reg)
                    begin
                        if (picks_reg != PICKS_MAX)
                        begin
                            picks_next = picks_reg + PICKS_W'(1);
                        end
                    end
                    else
                    begin
                        last_lvl_next = best_rec_reg[LW-1:0];
                        picks_next    = PICKS_W'(1);
                    end
                    boost_hit = (last_lvl_next == LAST_LEVEL)
                             && (CMP_W'(picks_next) >= CMP_W'(threshold));
                    if (boost_hit)
                    begin
                        run_rec_next[LW-1:0] = '0;
                        last_lvl_next  = '0;
                        picks_next     = '0;
                        res_boost_next = 1'b1;
                    end
                end
            end
            S_SORT:
            begin
                phase_next = phase_reg + IW'(1);
            end
            S_FLAT:
            begin
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [RW-1:0] left_in;
        logic [RW-1:0] right_in;
        cell_ctl_t     ctl;

        if (i < TABLE_DEPTH - 1)
        begin : g_right
            assign right_in = cell_rec[i+1];
            assign swap[i]  = (state_reg == S_SORT)
                           && (1'(i) == phase_reg[0])
                           && (CW'(i + 2) <= count_reg)
                           && (cell_rec[i][LW-1:0] > cell_rec[i+1][LW-1:0]);
        end
        else
        begin : g_right_end
            assign right_in = '0;
            assign swap[i]  = 1'b0;
        end

        if (i > 0)
        begin : g_left
            assign left_in       = cell_rec[i-1];
            assign ctl.take_left = swap[i-1];
        end
        else
        begin : g_left_end
            assign left_in       = '0;
            assign ctl.take_left = 1'b0;
        end

        assign ctl.load_new   = load_tail && (count_reg == CW'(i));
        assign ctl.take_right = ((state_reg == S_REMOVE)
                                 && (IW'(i) >= best_idx_reg)
                                 && (CW'(i + 1) < count_reg))
                              || swap[i];
        assign ctl.clr_level  = (state_reg == S_FLAT);

        psmq_cell #(
            .RW (RW),
            .LW (LW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .new_rec   (new_rec),
            .left_rec  (left_in),
            .right_rec (right_in),
            .rec       (cell_rec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POLICY_RESET;
            boost_mul_reg <= BOOST_RESET;
            count_reg     <= '0;
            rv_reg        <= 1'b0;
            run_rec_reg   <= '0;
            last_lvl_reg  <= '0;
            picks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            boost_mul_reg <= boost_mul_next;
            count_reg     <= count_next;
            rv_reg        <= rv_next;
            run_rec_reg   <= run_rec_next;
            last_lvl_reg  <= last_lvl_next;
            picks_reg     <= picks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        best_rec_reg   <= best_rec_next;
        phase_reg      <= phase_next;
        res_disp_reg   <= res_disp_next;
        res_boost_reg  <= res_boost_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            dispatched_reg <= res_disp_reg;
            run_id_reg     <= rv_reg ? run_rec_reg[RW-1 -: ID_W] : '0;
            run_level_reg  <= rv_reg ? RUNLVL_W'(run_rec_reg[LW-1:0]) : '0;
            boosted_reg    <= res_boost_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dispatched = dispatched_reg;
    assign run_id     = run_id_reg;
    assign run_level  = run_level_reg;
    assign boosted    = boosted_reg;
    assign status     = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (CW + 1)'(rv_reg)) <= (CW + 1)'(TABLE_DEPTH))
        else $error("queued and running threads exceed the table depth");

    a_remove_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |=> rv_reg)
        else $error("a pick did not leave a running thread");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the completion state");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan started on an empty table");

endmodule
`default_nettype wire

// ===== verif/psjf_mlfq_ready_scheduler_top_tb.sv =====
module psjf_mlfq_ready_scheduler_top_tb;
    import psmq_pkg::*;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int TOP_LEVEL  = DEF_LEVEL_COUNT - 1;
    localparam int unsigned ELAPSED_TOP = (1 << DEF_ELAPSED_BITS) - 1;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [ID_W-1:0] id;
        int unsigned     elapsed;
        int unsigned     level;
        bit              yield_odd;
    } thread_t;

    typedef struct packed {
        logic                dispatched;
        logic [ID_W-1:0]     run_id;
        logic [RUNLVL_W-1:0] run_level;
        logic                boosted;
        logic [STATUS_W-1:0] status;
    } sched_res_t;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] tid;
        bit              typed;
        sched_res_t      res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op = OP_ADD;
    logic [ID_W-1:0]     add_id = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                dispatched;
    logic [ID_W-1:0]     run_id;
    logic [RUNLVL_W-1:0] run_level;
    logic                boosted;
    logic [STATUS_W-1:0] status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_POLICY;
    logic [BOOST_W-1:0]  cfg_data = '0;

    thread_t     ready_tab[DEPTH];
    int          queued;
    bit          running;
    thread_t     run_rec;
    int unsigned last_level;
    int unsigned level_picks;
    logic        mode;
    int unsigned boost_mult;

    sched_res_t  pending_res[$];
    dir_row_t    dir_tab[$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          n_results = 0;
    int          n_boosts = 0;
    int          n_full = 0;

    psjf_mlfq_ready_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .add_id(add_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .dispatched(dispatched), .run_id(run_id), .run_level(run_level),
        .boosted(boosted), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void sched_reset();
        queued      = 0;
        running     = 1'b0;
        run_rec     = '{default: 0};
        last_level  = 0;
        level_picks = 0;
        mode        = POLICY_RESET;
        boost_mult  = BOOST_RESET;
    endfunction

    function automatic void enqueue(thread_t t);
        if (queued < DEPTH)
        begin
            ready_tab[queued] = t;
            queued++;
        end
    endfunction

    function automatic bit pick_next(output bit did_boost);
        int best;
        thread_t t;
        int j;
        did_boost = 1'b0;
        if (queued == 0)
            return 1'b0;
        best = 0;
        for (int i = 1; i < queued; i++)
        begin
            if (mode == POLICY_SJF ? ready_tab[i].elapsed < ready_tab[best].elapsed
                                   : ready_tab[i].level < ready_tab[best].level)
                best = i;
        end
        run_rec = ready_tab[best];
        running = 1'b1;
        for (int i = best; i + 1 < queued; i++)
            ready_tab[i] = ready_tab[i + 1];
        queued--;
        if (mode == POLICY_MLFQ)
        begin
            if (run_rec.level == last_level)
            begin
                if (level_picks < PICKS_MAX)
                    level_picks++;
            end
            else
            begin
                last_level  = run_rec.level;
                level_picks = 1;
            end
            if (last_level == TOP_LEVEL && level_picks >= boost_mult * queued)
            begin
                for (int i = 1; i < queued; i++)
                begin
                    t = ready_tab[i];
                    j = i;
                    while (j > 0 && ready_tab[j - 1].level > t.level)
                    begin
                        ready_tab[j] = ready_tab[j - 1];
                        j--;
                    end
                    ready_tab[j] = t;
                end
                for (int i = 0; i < queued; i++)
                    ready_tab[i].level = 0;
                run_rec.level = 0;
                last_level    = 0;
                level_picks   = 0;
                did_boost     = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic sched_res_t sched_step(logic [OP_W-1:0] o, logic [ID_W-1:0] tid);
        sched_res_t r;
        thread_t t;
        bit disp;
        bit bst;
        r = '0;
        disp = 1'b0;
        bst = 1'b0;
        r.status = ST_OK;
        if (o == OP_ADD)
        begin
            if (queued + int'(running) >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                t = '{id: tid, elapsed: 0, level: 0, yield_odd: 1'b0};
                enqueue(t);
            end
        end
        else if (o == OP_EXIT)
        begin
            if (!running)
                r.status = ST_NO_RUN;
            else
            begin
                running = 1'b0;
                run_rec = '{default: 0};
                disp = pick_next(bst);
                if (!disp)
                    r.status = ST_EMPTY;
            end
        end
        else
        begin
            if (running)
            begin
                if (o == OP_PREEMPT)
                begin
                    if (mode == POLICY_SJF)
                    begin
                        if (run_rec.elapsed < ELAPSED_TOP)
                            run_rec.elapsed++;
                    end
                    else if (run_rec.level < TOP_LEVEL)
                        run_rec.level++;
                end
                else if (mode == POLICY_SJF)
                begin
                    if (run_rec.yield_odd)
                    begin
                        run_rec.yield_odd = 1'b0;
                        if (run_rec.elapsed < ELAPSED_TOP)
                            run_rec.elapsed++;
                    end
                    else
                        run_rec.yield_odd = 1'b1;
                end
                enqueue(run_rec);
                running = 1'b0;
            end
            disp = pick_next(bst);
            if (!disp)
                r.status = ST_EMPTY;
        end
        r.dispatched = disp;
        r.run_id     = running ? run_rec.id : '0;
        r.run_level  = running ? run_rec.level[RUNLVL_W-1:0] : '0;
        r.boosted    = bst;
        return r;
    endfunction

    task automatic send_item(logic [OP_W-1:0] o, logic [ID_W-1:0] tid, bit typed,
                             sched_res_t typed_res);
        sched_res_t r;
        int gap;
        in_valid  <= 1'b1;
        op        <= o;
        add_id    <= tid;
        do
            @(posedge clk);
        while (in_stall);
        r = sched_step(o, tid);
        pending_res.push_back(typed ? typed_res : r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(12, 0);
            gap = $urandom_range(6, 0);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(logic idx, logic [BOOST_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY)
            mode = val[0];
        else
            boost_mult = val;
    endtask

    function automatic logic [OP_W-1:0] random_op();
        int roll;
        roll = $urandom_range(99, 0);
        if (queued + int'(running) < 3)
            return roll < 60 ? OP_ADD : roll[OP_W-1:0];
        if (roll < 25)
            return OP_ADD;
        if (roll < 60)
            return OP_PREEMPT;
        if (roll < 85)
            return OP_YIELD;
        return OP_EXIT;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        case ((cycles / 300) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(2, 0) == 0);
            default: out_stall <= ((cycles % 23) < 14);
        endcase
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors <= errors + 1;
            end
            else
            begin
                automatic sched_res_t e = pending_res.pop_front();
                automatic int bad = 0;
                if (dispatched !== e.dispatched)
                begin
                    $error("dispatched: expected %0d actual %0d", e.dispatched, dispatched);
                    bad++;
                end
                if (run_id !== e.run_id)
                begin
                    $error("run_id: expected %0d actual %0d", e.run_id, run_id);
                    bad++;
                end
                if (run_level !== e.run_level)
                begin
                    $error("run_level: expected %0d actual %0d", e.run_level, run_level);
                    bad++;
                end
                if (boosted !== e.boosted)
                begin
                    $error("boosted: expected %0d actual %0d", e.boosted, boosted);
                    bad++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, status);
                    bad++;
                end
                errors <= errors + bad;
                n_results <= n_results + 1;
                n_boosts  <= n_boosts + int'(boosted === 1'b1);
                n_full    <= n_full + int'(status === ST_FULL);
            end
        end
    end

    initial
    begin
        sched_res_t none_ok;
        dir_row_t row;
        none_ok = '{dispatched: 1'b0, run_id: '0, run_level: '0, boosted: 1'b0,
                    status: ST_OK};
        sched_reset();
        dir_tab.push_back('{OP_EXIT, 8'h00, 1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, ST_NO_RUN}});
        dir_tab.push_back('{OP_PREEMPT, 8'h00, 1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, ST_EMPTY}});
        dir_tab.push_back('{OP_YIELD, 8'hFF, 1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, ST_EMPTY}});
        dir_tab.push_back('{OP_ADD, 8'h00, 1'b1, none_ok});
        dir_tab.push_back('{OP_ADD, 8'hFF, 1'b1, none_ok});
        for (int i = 2; i < DEPTH; i++)
            dir_tab.push_back('{OP_ADD, ID_W'(8'h55 ^ (i * 17)), 1'b1, none_ok});
        dir_tab.push_back('{OP_ADD, 8'hAA, 1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, ST_FULL}});
        dir_tab.push_back('{OP_PREEMPT, 8'h00, 1'b0, none_ok});
        dir_tab.push_back('{OP_YIELD, 8'h00, 1'b0, none_ok});
        dir_tab.push_back('{OP_YIELD, 8'h00, 1'b0, none_ok});
        dir_tab.push_back('{OP_EXIT, 8'h00, 1'b0, none_ok});
        dir_tab.push_back('{OP_PREEMPT, 8'h00, 1'b0, none_ok});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            send_item(row.op, row.tid, row.typed, row.res);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: write_reg(CFG_POLICY, BOOST_W'(POLICY_MLFQ));
                1: write_reg(CFG_BOOST, 4'd1);
                2: write_reg(CFG_BOOST, 4'd15);
                3: write_reg(CFG_POLICY, BOOST_W'(POLICY_SJF));
                4: write_reg(CFG_POLICY, BOOST_W'(POLICY_MLFQ));
                5: write_reg(CFG_BOOST, 4'd0);
                default:
                begin
                    write_reg(CFG_POLICY, BOOST_W'($urandom_range(1, 0)));
                    write_reg(CFG_BOOST, BOOST_W'($urandom_range(15, 1)));
                end
            endcase
            for (int n = 0; n < 200; n++)
                send_item(random_op(), ID_W'($urandom), 1'b0, none_ok);
        end

        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d results over both policies and boost settings 0 to 15.",
                 n_results);
        $display("Saw %0d priority boosts and %0d table-full rejections.", n_boosts, n_full);
        if (errors == 0 && pending_res.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
